// ===== design/uifq_pkg.sv =====
// Package for the unique-insert FIFO queue: word types, request and status
// codes, and the structs passed between the top level, the chain and its cells.
// No dependencies.
package uifq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 31;
   localparam int OCC_W         = 5;

   // request codes
   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_POP    = 2'd1;
   localparam logic [1:0] REQ_SEARCH = 2'd2;

   // status codes
   localparam logic [2:0] STATUS_OK    = 3'd0;
   localparam logic [2:0] STATUS_DUP   = 3'd1;
   localparam logic [2:0] STATUS_NEG   = 3'd2;
   localparam logic [2:0] STATUS_FULL  = 3'd3;
   localparam logic [2:0] STATUS_EMPTY = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               found;
      logic [VALUE_W-1:0] popped_value;
      logic [VALUE_W-1:0] front_value;
      logic [VALUE_W-1:0] rear_value;
      logic [OCC_W-1:0]   occupancy;
      logic               is_empty;
   } rsp_word_type;

   // shared by all cells: shift towards the head, write at the fill point
   typedef struct packed {
      logic               pop_en;
      logic               push_en;
      logic [VALUE_W-1:0] key;
   } cell_ctrl_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic go;
      logic hit;
   } scan_type;

endpackage

// ===== design/uifq_cell.sv =====
// One cell of the queue chain: holds one value, shifts it on pop,
// compares it with the search key as the scan token passes. Uses uifq_pkg.
module uifq_cell #(
   parameter int IDX   = 0,
   parameter int DEPTH = uifq_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  uifq_pkg::cell_ctrl_type          ctrl,
   input  logic [$clog2(DEPTH+1)-1:0]       count,
   input  logic [uifq_pkg::VALUE_W-1:0]     nbr_data,
   input  uifq_pkg::scan_type               scan_in,
   output logic [uifq_pkg::VALUE_W-1:0]     data,
   output uifq_pkg::scan_type               scan_out
);

   localparam int CountW = $clog2(DEPTH+1);

   logic [uifq_pkg::VALUE_W-1:0] data_ff;
   uifq_pkg::scan_type           scan_ff;
   uifq_pkg::scan_type           scan_in_next;
   logic                         occupied;

   assign occupied = CountW'(IDX) < count;

   always_comb begin
      scan_in_next.go  = scan_in.go;
      scan_in_next.hit = scan_in.hit | (occupied && (data_ff == ctrl.key));
   end

   // payload: take the neighbour's value on pop, the key on push at the fill point
   always_ff @(posedge clock) begin
      if (ctrl.pop_en) begin
         data_ff <= nbr_data;
      end else if (ctrl.push_en && (count == CountW'(IDX))) begin
         data_ff <= ctrl.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in_next;
      end
   end

   assign data     = data_ff;
   assign scan_out = scan_ff;

endmodule

// ===== design/uifq_chain.sv =====
// Row of DEPTH queue cells, oldest value in cell 0. Wires the shift path
// and the search token path. Uses uifq_pkg and uifq_cell.
module uifq_chain #(
   parameter int DEPTH = uifq_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  uifq_pkg::cell_ctrl_type          ctrl,
   input  logic [$clog2(DEPTH+1)-1:0]       count,
   input  logic                             scan_start,
   output logic [uifq_pkg::VALUE_W-1:0]     head_data,
   output logic [uifq_pkg::VALUE_W-1:0]     second_data,
   output uifq_pkg::scan_type               scan_tail
);

   uifq_pkg::scan_type           scan_link [0:DEPTH];
   logic [uifq_pkg::VALUE_W-1:0] cell_data [0:DEPTH-1];

   assign scan_link[0].go  = scan_start;
   assign scan_link[0].hit = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [uifq_pkg::VALUE_W-1:0] nbr;
      if (i == DEPTH - 1) begin : g_last
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_data[i+1];
      end

      uifq_cell #(
         .IDX   (i),
         .DEPTH (DEPTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .count    (count),
         .nbr_data (nbr),
         .scan_in  (scan_link[i]),
         .data     (cell_data[i]),
         .scan_out (scan_link[i+1])
      );
   end

   assign head_data   = cell_data[0];
   assign second_data = cell_data[1];
   assign scan_tail   = scan_link[DEPTH];

endmodule

// ===== design/unique_insert_fifo_queue.sv =====
// Unique-insert FIFO queue: push if new, pop oldest, search.
// Push and search of a non-negative value launch a search token that walks the
// cell chain one cell a cycle; the hit is then captured, the step finished and the
// sequencer is back in idle; pop, unused codes and negative values go straight to the
// finish. A waiting result word stalls the finish. The result word is registered at the
// finish, and a new request word is taken while it still waits. Synchronous active-high reset empties it.
module unique_insert_fifo_queue #(
   parameter int DEPTH = uifq_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  uifq_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output uifq_pkg::rsp_word_type rsp_data
);

   localparam int CountW = $clog2(DEPTH+1);
   localparam int OccW   = uifq_pkg::OCC_W;
   localparam int ValW   = uifq_pkg::VALUE_W;

   // control states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            op_ff;
   logic                  neg_ff;
   logic [ValW-1:0]       key_ff;
   logic                  hit_ff, hit_in;
   logic                  start_ff;
   logic [CountW-1:0]     count_ff, count_in;
   logic [ValW-1:0]       rear_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   uifq_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic                    req_fire;
   logic                    needs_scan;
   logic                    out_free;
   logic                    finish_go;
   logic                    q_empty, q_full;
   logic                    push_ok, pop_ok;
   logic [2:0]              status;
   logic [ValW-1:0]         front_next, rear_next;
   logic [ValW-1:0]         head_data, second_data;
   uifq_pkg::scan_type      scan_tail;
   uifq_pkg::cell_ctrl_type ctrl;

   // ---------------------------------------------------------------
   // Request side: one word in flight, scan launched for push/search
   // of a non-negative value only.
   // ---------------------------------------------------------------
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign needs_scan = ((req_data.req_type == uifq_pkg::REQ_PUSH) ||
                        (req_data.req_type == uifq_pkg::REQ_SEARCH)) &&
                       !req_data.value[31];

   // result slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish_go = (state_ff == S_FINISH) && out_free;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CountW'(DEPTH));

   // ---------------------------------------------------------------
   // Decide the outcome once the scan result is in hit_ff.
   // Order of checks on push: negative, duplicate, full.
   // ---------------------------------------------------------------
   always_comb begin
      status  = uifq_pkg::STATUS_OK;
      push_ok = 1'b0;
      pop_ok  = 1'b0;
      case (op_ff)
         uifq_pkg::REQ_PUSH: begin
            if (neg_ff) begin
               status = uifq_pkg::STATUS_NEG;
            end else if (hit_ff) begin
               status = uifq_pkg::STATUS_DUP;
            end else if (q_full) begin
               status = uifq_pkg::STATUS_FULL;
            end else begin
               push_ok = 1'b1;
            end
         end
         uifq_pkg::REQ_POP: begin
            if (q_empty) begin
               status = uifq_pkg::STATUS_EMPTY;
            end else begin
               pop_ok = 1'b1;
            end
         end
         default: begin
            status = uifq_pkg::STATUS_OK;
         end
      endcase
   end

   // front and rear after the step; zero when the queue ends up empty
   always_comb begin
      if (push_ok) begin
         front_next = q_empty ? key_ff : head_data;
         rear_next  = key_ff;
      end else if (pop_ok) begin
         front_next = (count_ff == CountW'(1)) ? '0 : second_data;
         rear_next  = (count_ff == CountW'(1)) ? '0 : rear_ff;
      end else begin
         front_next = q_empty ? '0 : head_data;
         rear_next  = q_empty ? '0 : rear_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (finish_go && push_ok) begin
         count_in = count_ff + CountW'(1);
      end else if (finish_go && pop_ok) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_comb begin
      rsp_data_in.status       = status;
      rsp_data_in.found        = (op_ff == uifq_pkg::REQ_SEARCH) && hit_ff;
      rsp_data_in.popped_value = pop_ok ? head_data : '0;
      rsp_data_in.front_value  = front_next;
      rsp_data_in.rear_value   = rear_next;
      rsp_data_in.occupancy    = OccW'(count_in);
      rsp_data_in.is_empty     = (count_in == '0);
   end

   // cell commands: shift on pop, write at the fill point on push
   always_comb begin
      ctrl.pop_en  = finish_go && pop_ok;
      ctrl.push_en = finish_go && push_ok;
      ctrl.key     = key_ff;
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               hit_in   = 1'b0;
               state_in = needs_scan ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (scan_tail.go) begin
               hit_in   = scan_tail.hit;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hit_ff       <= 1'b0;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         start_ff     <= req_fire && needs_scan;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request word while it is worked on; capture the result word and the rear value at the finish
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_data.req_type;
         neg_ff <= req_data.value[31];
         key_ff <= req_data.value[ValW-1:0];
      end
      if (finish_go) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (finish_go && push_ok) begin
         rear_ff <= key_ff;
      end
   end

   uifq_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .count       (count_ff),
      .scan_start  (start_ff),
      .head_data   (head_data),
      .second_data (second_data),
      .scan_tail   (scan_tail)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(DEPTH))
      else $error("occupancy beyond depth");

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_tail.go |-> (state_ff == S_SCAN))
      else $error("search token left the chain outside a scan");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_SCAN) || (state_ff == S_FINISH))
      else $error("sequencer idle after accepting a word");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      finish_go |=> rsp_data_ff.is_empty == (count_ff == '0))
      else $error("empty flag disagrees with occupancy");
`endif

endmodule

// ===== bench/uifq_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the unique-insert FIFO queue: predicts each result word and compares it.
// Depends on uifq_pkg for the word types and the request and status codes.
module uifq_checker #(
   parameter int DEPTH = uifq_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  uifq_pkg::req_word_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  uifq_pkg::rsp_word_type rsp_data,
   output int                     failures,
   output int                     pending
);

   localparam int REPORT_MAX = 10;

   logic [uifq_pkg::VALUE_W-1:0] held_values[$];
   uifq_pkg::rsp_word_type       expected_words[$];
   int                           words_checked;

   // Apply one request to the mirror queue and return the result word it causes.
   function automatic uifq_pkg::rsp_word_type apply_request(input uifq_pkg::req_word_type w);
      uifq_pkg::rsp_word_type       r;
      logic                         negative;
      logic [uifq_pkg::VALUE_W-1:0] key;
      logic                         present;
      r        = '0;
      negative = w.value[31];
      key      = w.value[uifq_pkg::VALUE_W-1:0];
      present  = 1'b0;
      foreach (held_values[i])
         if (held_values[i] == key) present = 1'b1;
      case (w.req_type)
         uifq_pkg::REQ_PUSH: begin
            if (negative) r.status = uifq_pkg::STATUS_NEG;
            else if (present) r.status = uifq_pkg::STATUS_DUP;
            else if (held_values.size() >= DEPTH) r.status = uifq_pkg::STATUS_FULL;
            else held_values.push_back(key);
         end
         uifq_pkg::REQ_POP: begin
            if (held_values.size() == 0) r.status = uifq_pkg::STATUS_EMPTY;
            else r.popped_value = held_values.pop_front();
         end
         uifq_pkg::REQ_SEARCH: r.found = !negative && present;
         default: ;
      endcase
      if (held_values.size() != 0) begin
         r.front_value = held_values[0];
         r.rear_value  = held_values[held_values.size() - 1];
      end
      r.occupancy = uifq_pkg::OCC_W'(held_values.size());
      r.is_empty  = (held_values.size() == 0);
      return r;
   endfunction

   initial begin
      failures      = 0;
      pending       = 0;
      words_checked = 0;
   end

   always @(posedge clock) begin
      uifq_pkg::rsp_word_type want;
      if (!reset) begin
         // compare first: a word accepted in this cycle cannot answer this cycle's request
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               if (failures < REPORT_MAX)
                  $display("%0t: result word with nothing expected: %h", $realtime, rsp_data);
               failures++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.status !== want.status || rsp_data.found !== want.found ||
                   rsp_data.popped_value !== want.popped_value ||
                   rsp_data.front_value !== want.front_value ||
                   rsp_data.rear_value !== want.rear_value ||
                   rsp_data.occupancy !== want.occupancy ||
                   rsp_data.is_empty !== want.is_empty) begin
                  if (failures < REPORT_MAX) begin
                     $display("%0t: word %0d exp st=%0d fd=%0b pop=%h fr=%h re=%h occ=%0d emp=%0b",
                              $realtime, words_checked, want.status, want.found,
                              want.popped_value, want.front_value, want.rear_value,
                              want.occupancy, want.is_empty);
                     $display("%0t: word %0d got st=%0d fd=%0b pop=%h fr=%h re=%h occ=%0d emp=%0b",
                              $realtime, words_checked, rsp_data.status, rsp_data.found,
                              rsp_data.popped_value, rsp_data.front_value,
                              rsp_data.rear_value, rsp_data.occupancy, rsp_data.is_empty);
                  end
                  failures++;
               end
            end
            words_checked++;
         end
         if (req_valid && req_ready)
            expected_words.push_back(apply_request(req_data));
      end
      pending = expected_words.size();
   end

endmodule

// ===== bench/tb_unique_insert_fifo_queue.sv =====
`timescale 1ns / 1ps
// Top of the bench for the unique-insert FIFO queue: clock, reset, request and result traffic.
// Depends on uifq_pkg, unique_insert_fifo_queue and uifq_checker.
module tb_unique_insert_fifo_queue;

   localparam int         DEPTH        = uifq_pkg::DEPTH_DEFAULT;
   localparam int         RANDOM_WORDS = 650;
   localparam int         IDLE_PCT     = 38;
   // no idling on either side for this window of random words
   localparam int         STEADY_FROM  = 150;
   localparam int         STEADY_TO    = 270;
   // the receiver stalls for a long stretch once this many words have gone in
   localparam int         HOLD_AT      = 420;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         IDLE_LIMIT   = 3000;
   // extra wait after the last result word, scaled with the chain depth
   localparam int         DRAIN_CYCLES = 2 * (DEPTH + 2);
   localparam int         POOL_SIZE    = 24;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   uifq_pkg::req_word_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   uifq_pkg::rsp_word_type rsp_data;
   int                     failures;
   int                     pending;

   int           words_sent = 0;
   logic         steady     = 1'b0;
   int           idle_cycles = 0;
   logic [31:0]  value_pool[POOL_SIZE];

   always #6 clock = ~clock;

   unique_insert_fifo_queue #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   uifq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .failures (failures),
      .pending  (pending)
   );

   function automatic uifq_pkg::req_word_type make_word(input logic [1:0] kind,
                                                        input logic [31:0] v);
      uifq_pkg::req_word_type w;
      w.req_type = kind;
      w.value    = v;
      return w;
   endfunction

   // Mostly pool values so that duplicates and search hits are common; now and then a
   // full 32-bit value, negative about half of those times.
   function automatic logic [31:0] pick_value();
      if ($urandom_range(99) < 12) return $urandom;
      return value_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic uifq_pkg::req_word_type random_word(input traffic_mode_type mode);
      int          roll;
      logic [1:0]  kind;
      roll = $urandom_range(99);
      case (mode)
         MODE_FILL:  kind = (roll < 75) ? uifq_pkg::REQ_PUSH :
                            (roll < 90) ? uifq_pkg::REQ_SEARCH :
                            (roll < 97) ? uifq_pkg::REQ_POP : REQ_UNUSED;
         MODE_DRAIN: kind = (roll < 62) ? uifq_pkg::REQ_POP :
                            (roll < 82) ? uifq_pkg::REQ_PUSH :
                            (roll < 97) ? uifq_pkg::REQ_SEARCH : REQ_UNUSED;
         default:    kind = (roll < 40) ? uifq_pkg::REQ_PUSH :
                            (roll < 70) ? uifq_pkg::REQ_POP :
                            (roll < 96) ? uifq_pkg::REQ_SEARCH : REQ_UNUSED;
      endcase
      return make_word(kind, pick_value());
   endfunction

   // Offer one word from a falling edge and hold it until it is taken; return on the
   // falling edge after acceptance so that the next word can follow without a gap.
   task automatic send_word(input uifq_pkg::req_word_type w);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      @(negedge clock);
   endtask

   // Receiver: random stalls, none in the steady window, and one long hold-off that lets
   // the block fill up and push back on the sender.
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && words_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      traffic_mode_type mode;
      int               run_len;
      int               random_sent;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = {1'b0, 31'($urandom)};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty queue, negative and extreme values, duplicates, searches whose
      // low bits match a held value but whose sign bit is set, the unused code
      send_word(make_word(uifq_pkg::REQ_POP,    32'h0000_0000));
      send_word(make_word(uifq_pkg::REQ_SEARCH, 32'h0000_0000));
      send_word(make_word(uifq_pkg::REQ_PUSH,   32'hFFFF_FFFF));
      send_word(make_word(uifq_pkg::REQ_PUSH,   32'h8000_0000));
      send_word(make_word(uifq_pkg::REQ_PUSH,   32'h0000_0000));
      send_word(make_word(uifq_pkg::REQ_PUSH,   32'h7FFF_FFFF));
      send_word(make_word(uifq_pkg::REQ_PUSH,   32'h0000_0000));
      send_word(make_word(uifq_pkg::REQ_PUSH,   32'h7FFF_FFFF));
      send_word(make_word(uifq_pkg::REQ_SEARCH, 32'h7FFF_FFFF));
      send_word(make_word(uifq_pkg::REQ_SEARCH, 32'hFFFF_FFFF));
      send_word(make_word(uifq_pkg::REQ_SEARCH, 32'h8000_0000));
      send_word(make_word(uifq_pkg::REQ_SEARCH, 32'h0000_0005));
      send_word(make_word(REQ_UNUSED,           32'h0000_0000));
      send_word(make_word(REQ_UNUSED,           32'hFFFF_FFFF));
      send_word(make_word(uifq_pkg::REQ_POP,    32'hFFFF_FFFF));
      send_word(make_word(uifq_pkg::REQ_PUSH,   32'h5555_5555));
      send_word(make_word(uifq_pkg::REQ_PUSH,   32'h2AAA_AAAA));
      send_word(make_word(uifq_pkg::REQ_POP,    32'h0000_0000));
      send_word(make_word(uifq_pkg::REQ_POP,    32'h0000_0000));
      send_word(make_word(uifq_pkg::REQ_POP,    32'h0000_0000));
      send_word(make_word(uifq_pkg::REQ_POP,    32'h0000_0000));

      // random: runs of fill, drain and mixed traffic so the queue swings between
      // empty and full
      random_sent = 0;
      while (random_sent < RANDOM_WORDS) begin
         case ($urandom_range(2))
            0:       mode = MODE_FILL;
            1:       mode = MODE_DRAIN;
            default: mode = MODE_MIX;
         endcase
         run_len = $urandom_range(40, 10);
         for (int i = 0; i < run_len && random_sent < RANDOM_WORDS; i++) begin
            steady = (random_sent >= STEADY_FROM && random_sent < STEADY_TO);
            send_word(random_word(mode));
            random_sent++;
         end
      end
      steady    = 1'b0;
      req_valid <= 1'b0;

      // drain: the watchdog catches a result that never comes
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
